@@ rtl/dfd_pkg.sv @@
package dfd_pkg;

    localparam int CFG_DATA_W = 16;

    localparam logic CFG_EXPECTED_MAGIC   = 1'b0;
    localparam logic CFG_EXPECTED_VERSION = 1'b1;

    localparam logic KIND_PAYLOAD   = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TRUNCATED = 2'd1;
    localparam logic [1:0] ST_BAD_MAGIC = 2'd2;
    localparam logic [1:0] ST_BAD_VER   = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_datagram;
    } t_in_item;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [1:0]  frame_status;
        logic [7:0]  message_type;
        logic [15:0] sequence_number;
        logic [7:0]  frame_flags;
        logic [15:0] payload_length;
        logic [15:0] check_word;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item item;
    } t_parse_res;

endpackage

@@ rtl/dfd_parser.sv @@
module dfd_parser
    import dfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  t_in_item              i_item,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_parse_res            o_res
);

    typedef enum logic [3:0] {
        PH_MAGIC_HI = 4'd0,
        PH_MAGIC_LO = 4'd1,
        PH_VERSION  = 4'd2,
        PH_TYPE     = 4'd3,
        PH_SEQ_HI   = 4'd4,
        PH_SEQ_LO   = 4'd5,
        PH_FLAGS    = 4'd6,
        PH_LEN_HI   = 4'd7,
        PH_LEN_LO   = 4'd8,
        PH_PAYLOAD  = 4'd9,
        PH_CHECK_HI = 4'd10,
        PH_CHECK_LO = 4'd11
    } t_phase;

    t_phase      r_phase, n_phase;
    logic        r_finished, n_finished;
    logic [7:0]  r_hold, n_hold;
    logic [7:0]  r_type, n_type;
    logic [15:0] r_seq, n_seq;
    logic [7:0]  r_flags, n_flags;
    logic [15:0] r_len, n_len;
    logic [15:0] r_remain, n_remain;
    logic [15:0] r_magic;
    logic [7:0]  r_version;

    logic [7:0]  b;
    logic        eod;
    logic [15:0] word;
    logic        ended;
    logic [1:0]  end_status;
    logic [15:0] end_check;

    assign b    = i_item.data_byte;
    assign eod  = i_item.end_of_datagram;
    assign word = {r_hold, b};

    always_comb begin
        n_phase    = r_phase;
        n_finished = r_finished;
        n_hold     = r_hold;
        n_type     = r_type;
        n_seq      = r_seq;
        n_flags    = r_flags;
        n_len      = r_len;
        n_remain   = r_remain;
        ended      = 1'b0;
        end_status = ST_OK;
        end_check  = '0;
        o_res      = '0;

        if (r_finished) begin
            if (eod) begin
                n_finished = 1'b0;
                n_phase    = PH_MAGIC_HI;
            end
        end else begin
            case (r_phase)
                PH_MAGIC_LO: begin
                    if (word != r_magic) begin
                        ended      = 1'b1;
                        end_status = ST_BAD_MAGIC;
                    end else begin
                        n_phase = PH_VERSION;
                    end
                end
                PH_VERSION: begin
                    if (b != r_version) begin
                        ended      = 1'b1;
                        end_status = ST_BAD_VER;
                    end else begin
                        n_phase = PH_TYPE;
                    end
                end
                PH_TYPE: begin
                    n_type  = b;
                    n_phase = PH_SEQ_HI;
                end
                PH_SEQ_HI: begin
                    n_hold  = b;
                    n_phase = PH_SEQ_LO;
                end
                PH_SEQ_LO: begin
                    n_seq   = word;
                    n_phase = PH_FLAGS;
                end
                PH_FLAGS: begin
                    n_flags = b;
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_hold  = b;
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len    = word;
                    n_remain = word;
                    n_phase  = (word == '0) ? PH_CHECK_HI : PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    o_res.valid             = 1'b1;
                    o_res.item.result_kind  = KIND_PAYLOAD;
                    o_res.item.payload_byte = b;
                    n_remain                = r_remain - 16'd1;
                    if (n_remain == '0) begin
                        n_phase = PH_CHECK_HI;
                    end
                end
                PH_CHECK_HI: begin
                    n_hold  = b;
                    n_phase = PH_CHECK_LO;
                end
                PH_CHECK_LO: begin
                    ended      = 1'b1;
                    end_status = ST_OK;
                    end_check  = word;
                end
                default: begin
                    n_type   = '0;
                    n_seq    = '0;
                    n_flags  = '0;
                    n_len    = '0;
                    n_remain = '0;
                    n_hold   = b;
                    n_phase  = PH_MAGIC_LO;
                end
            endcase

            if (ended || eod) begin
                o_res.valid                = 1'b1;
                o_res.item.result_kind     = KIND_FRAME_END;
                o_res.item.payload_byte    = '0;
                o_res.item.frame_status    = ended ? end_status : ST_TRUNCATED;
                o_res.item.message_type    = n_type;
                o_res.item.sequence_number = n_seq;
                o_res.item.frame_flags     = n_flags;
                o_res.item.payload_length  = n_len;
                o_res.item.check_word      = ended ? end_check : 16'd0;
                if (eod) begin
                    n_phase    = PH_MAGIC_HI;
                    n_finished = 1'b0;
                end else begin
                    n_finished = 1'b1;
                end
            end
        end

        if (!i_accept) begin
            o_res.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_MAGIC_HI;
            r_finished <= 1'b0;
            r_magic    <= '0;
            r_version  <= '0;
        end else begin
            if (i_accept) begin
                r_phase    <= n_phase;
                r_finished <= n_finished;
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_EXPECTED_MAGIC:   r_magic   <= i_cfg_wdata;
                    CFG_EXPECTED_VERSION: r_version <= i_cfg_wdata[7:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_hold   <= n_hold;
            r_type   <= n_type;
            r_seq    <= n_seq;
            r_flags  <= n_flags;
            r_len    <= n_len;
            r_remain <= n_remain;
        end
    end

endmodule

@@ rtl/datagram_frame_decoder.sv @@
// Datagram frame decoder.
// Input channel: one datagram byte per transfer (i_in_valid / o_in_stall),
// with end_of_datagram set on the last byte. Output channel
// (o_out_valid / i_out_stall): one result per payload byte, and one
// frame-end result per datagram carrying the header fields and a status
// (ok, truncated, bad magic, bad version). Bytes after the frame end are
// dropped until the end-of-datagram byte.
// Configuration: write expected magic (index 0) and expected version
// (index 1) through i_cfg_we / i_cfg_addr / i_cfg_wdata while idle.
// Throughput: one byte per cycle while o_in_stall is low; header parse
// and result are formed combinationally from the phase register. Each
// result enters the output register, or the skid register if the output
// is stalled. They decouple the channels: o_in_stall rises only when
// both hold a result, after the receiver stalled a full output register.
// Reset (synchronous, active low) clears both registers' valid flags, the
// parser phase and the configuration registers; the block then expects
// the first magic byte.
module datagram_frame_decoder
    import dfd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic       in_accept;
    logic       slot_free;
    t_parse_res res;

    logic       r_out_valid;
    t_out_item  r_out;
    logic       r_skid_valid;
    t_out_item  r_skid;

    assign in_accept = i_in_valid && !r_skid_valid;
    assign slot_free = !r_out_valid || !i_out_stall;

    dfd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_item      (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (slot_free) begin
                r_out        <= r_skid;
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (res.valid) begin
            if (slot_free) begin
                r_out       <= res.item;
                r_out_valid <= 1'b1;
            end else begin
                r_skid       <= res.item;
                r_skid_valid <= 1'b1;
            end
        end else if (slot_free) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ rtl/dfd_checker.sv @@
module dfd_checker
    import dfd_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_stall,
    input logic      i_out_valid,
    input logic      i_out_stall,
    input t_out_item i_out_data
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_stall)
        else $error("outputs not cleared by reset");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_stall |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.result_kind == KIND_PAYLOAD
        |-> i_out_data.frame_status == ST_OK && i_out_data.check_word == 16'd0
            && i_out_data.payload_length == 16'd0)
        else $error("payload result carries header fields");

    a_check_ok_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.frame_status != ST_OK
        |-> i_out_data.check_word == 16'd0)
        else $error("check word on failed frame");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_in_stall) |-> $past(i_out_valid && i_out_stall))
        else $error("input stalled without output backpressure");

endmodule

bind datagram_frame_decoder dfd_checker u_dfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
